[hw/rtl/bsort_pkg.sv]
// Shared types for the bitonic sorter: controller states and sequencer control words.
package bsort_pkg;

   // Width of the key ports and the result key port.
   localparam int KEY_PORT_W = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SORT_RD,
      ST_SORT_WR,
      ST_EMIT_RD,
      ST_EMIT_LD
   } bsort_state_type;

   typedef struct packed {
      logic start;
      logic step;
   } seq_ctl_type;

   typedef struct packed {
      logic done;
      logic skip;
   } seq_sts_type;

endpackage

[hw/rtl/bsort_seq.sv]
// Compare schedule generator: walks the stages of an ascending bitonic network.
module bsort_seq import bsort_pkg::*; #(
   parameter int ADDR_W = 6,
   parameter int CNT_W  = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  seq_ctl_type       seq_ctl,
   input  logic [CNT_W-1:0]  item_count,
   output seq_sts_type       seq_sts,
   output logic [ADDR_W-1:0] idx_lo,
   output logic [ADDR_W-1:0] idx_hi
);

   localparam int LG_W  = $clog2(ADDR_W + 1);
   localparam int IDX_W = ADDR_W + 1;

   logic [LG_W-1:0]   stage_ff, stage_in;
   logic [LG_W-1:0]   sub_ff, sub_in;
   logic [ADDR_W-1:0] pair_ff, pair_in;
   logic              done_ff, done_in;

   logic [IDX_W-1:0]  n_ext;
   logic [LG_W-1:0]   lg;
   logic [LG_W-1:0]   sub_p1;
   logic [ADDR_W-1:0] pairs_m1;
   logic [ADDR_W-1:0] lo_mask;
   logic              flip;
   logic [IDX_W-1:0]  partner;

   assign n_ext = IDX_W'(item_count);

   // Smallest power of two that covers the set; the rest of it is virtual padding.
   always_comb begin
      lg = '0;
      for (int b = ADDR_W; b >= 0; b--) begin
         if ((IDX_W'(1) << b) >= n_ext) begin
            lg = LG_W'(b);
         end
      end
   end

   assign sub_p1   = LG_W'(sub_ff + 1'b1);
   assign pairs_m1 = ADDR_W'((IDX_W'(1) << LG_W'(lg - 1'b1)) - 1'b1);
   assign lo_mask  = ADDR_W'((IDX_W'(1) << sub_ff) - 1'b1);
   assign flip     = (sub_ff == LG_W'(stage_ff - 1'b1));

   // The lower index of a pair has a zero inserted at the bit of the current distance.
   assign idx_lo  = ADDR_W'(((pair_ff >> sub_ff) << sub_p1) | (pair_ff & lo_mask));
   assign partner = flip ? ({1'b0, idx_lo} ^ ((IDX_W'(1) << sub_p1) - 1'b1))
                         : ({1'b0, idx_lo} | (IDX_W'(1) << sub_ff));
   assign idx_hi  = partner[ADDR_W-1:0];

   assign seq_sts.skip = (partner >= n_ext);
   assign seq_sts.done = done_ff || (lg == '0);

   always_comb begin
      stage_in = stage_ff;
      sub_in   = sub_ff;
      pair_in  = pair_ff;
      done_in  = done_ff;
      if (seq_ctl.start) begin
         stage_in = LG_W'(1);
         sub_in   = '0;
         pair_in  = '0;
         done_in  = 1'b0;
      end else if (seq_ctl.step) begin
         if (pair_ff == pairs_m1) begin
            pair_in = '0;
            if (sub_ff == '0) begin
               if (stage_ff == lg) begin
                  done_in = 1'b1;
               end else begin
                  stage_in = LG_W'(stage_ff + 1'b1);
                  sub_in   = stage_ff;
               end
            end else begin
               sub_in = LG_W'(sub_ff - 1'b1);
            end
         end else begin
            pair_in = ADDR_W'(pair_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= LG_W'(1);
         sub_ff   <= '0;
         pair_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         sub_ff   <= sub_in;
         pair_ff  <= pair_in;
         done_ff  <= done_in;
      end
   end

endmodule

[hw/rtl/bitonic_sorter.sv]
// Bitonic sorter for any set size up to MAX_ITEMS, built around one key memory.
// Keys are loaded while the sorter is idle; the word marked last starts the sort, in which
// each compare-exchange of the padded network takes a read and a write state, a skipped pair
// only a read state, and a last read state ends the sort; each result word then takes an
// EMIT_RD and an EMIT_LD state, EMIT_RD waiting on rsp_stall; the key memory has one write port.
// Reset clears the controller, count and direction register; the key memory is not cleared.
module bitonic_sorter import bsort_pkg::*; #(
   parameter int MAX_ITEMS = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KEY_PORT_W-1:0] req_key,
   input  logic                  req_last_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KEY_PORT_W-1:0] rsp_sorted_key,
   output logic                  rsp_last_out,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);

   localparam int ADDR_W = $clog2(MAX_ITEMS);
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

   // The network sorts ascending over the next power of two; slots past the set
   // act as keys larger than any real key, so any compare that reaches one is skipped.
   // A descending set is read out from the top of the memory down.

   bsort_state_type state_ff, state_in;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      emit_ff, emit_in;
   logic                  desc_cfg_ff;
   logic                  desc_ff;

   // Key memory: one write port, two registered read ports.
   logic [KEY_WIDTH-1:0]  key_mem [MAX_ITEMS];
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [KEY_WIDTH-1:0]  mem_wdata;
   logic [ADDR_W-1:0]     rd_addr_a;
   logic [ADDR_W-1:0]     rd_addr_b;
   logic [KEY_WIDTH-1:0]  rd_a_ff;
   logic [KEY_WIDTH-1:0]  rd_b_ff;

   // Compare-exchange pipeline: the upper result of a pair is written in the cycle after the lower one.
   logic [ADDR_W-1:0]     pair_lo_ff;
   logic [ADDR_W-1:0]     hi_addr_ff;
   logic [KEY_WIDTH-1:0]  hi_key_ff;
   logic                  hi_pend_ff;
   logic                  fwd_lo_ff;
   logic                  fwd_hi_ff;

   logic                  rsp_valid_ff;
   logic [KEY_PORT_W-1:0] rsp_key_ff;
   logic                  rsp_last_ff;

   seq_ctl_type           seq_ctl;
   seq_sts_type           seq_sts;
   logic [ADDR_W-1:0]     seq_lo;
   logic [ADDR_W-1:0]     seq_hi;

   logic                  req_take;
   logic                  store_room;
   logic                  issue;
   logic [KEY_WIDTH-1:0]  key_in;
   logic [KEY_WIDTH-1:0]  cmp_a;
   logic [KEY_WIDTH-1:0]  cmp_b;
   logic                  cmp_swap;
   logic [KEY_WIDTH-1:0]  cmp_min;
   logic [KEY_WIDTH-1:0]  cmp_max;
   logic [CNT_W-1:0]      last_idx;
   logic                  emit_last;
   logic [ADDR_W-1:0]     emit_addr;
   logic [KEY_PORT_W-1:0] emit_key;
   logic                  out_free;

   // Keys are kept at KEY_WIDTH bits and shown on the result port at port width.
   if (KEY_WIDTH >= KEY_PORT_W) begin : g_wide_key
      assign key_in   = KEY_WIDTH'(req_key);
      assign emit_key = rd_a_ff[KEY_PORT_W-1:0];
   end else begin : g_narrow_key
      assign key_in   = req_key[KEY_WIDTH-1:0];
      assign emit_key = KEY_PORT_W'(rd_a_ff);
   end

   bsort_seq #(
      .ADDR_W (ADDR_W),
      .CNT_W  (CNT_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .seq_ctl    (seq_ctl),
      .item_count (count_ff),
      .seq_sts    (seq_sts),
      .idx_lo     (seq_lo),
      .idx_hi     (seq_hi)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign store_room = (count_ff < CNT_W'(MAX_ITEMS));
   assign issue      = (state_ff == ST_SORT_RD) && !seq_sts.done && !seq_sts.skip;

   // An operand whose entry is being written back in the read cycle comes from the hold register.
   assign cmp_a    = fwd_lo_ff ? hi_key_ff : rd_a_ff;
   assign cmp_b    = fwd_hi_ff ? hi_key_ff : rd_b_ff;
   assign cmp_swap = (cmp_a > cmp_b);
   assign cmp_min  = cmp_swap ? cmp_b : cmp_a;
   assign cmp_max  = cmp_swap ? cmp_a : cmp_b;

   assign last_idx  = CNT_W'(count_ff - 1'b1);
   assign emit_last = (emit_ff == last_idx);
   assign emit_addr = desc_ff ? ADDR_W'(last_idx - emit_ff) : ADDR_W'(emit_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_last_item) begin
               state_in = ST_SORT_RD;
            end
         end
         ST_SORT_RD: begin
            if (seq_sts.done) begin
               state_in = ST_EMIT_RD;
            end else if (!seq_sts.skip) begin
               state_in = ST_SORT_WR;
            end
         end
         ST_SORT_WR: begin
            state_in = ST_SORT_RD;
         end
         ST_EMIT_RD: begin
            if (out_free) begin
               state_in = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD: begin
            if (emit_last) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory port and sequencer control for each state.
   always_comb begin
      mem_we        = 1'b0;
      mem_waddr     = hi_addr_ff;
      mem_wdata     = hi_key_ff;
      rd_addr_a     = seq_lo;
      rd_addr_b     = seq_hi;
      seq_ctl.start = 1'b0;
      seq_ctl.step  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            mem_we        = req_take && store_room;
            mem_waddr     = count_ff[ADDR_W-1:0];
            mem_wdata     = key_in;
            seq_ctl.start = req_take && req_last_item;
         end
         ST_SORT_RD: begin
            mem_we       = hi_pend_ff;
            seq_ctl.step = !seq_sts.done;
         end
         ST_SORT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = pair_lo_ff;
            mem_wdata = cmp_min;
         end
         ST_EMIT_RD: begin
            rd_addr_a = emit_addr;
         end
         ST_EMIT_LD: begin
            rd_addr_a = emit_addr;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= key_mem[rd_addr_a];
      rd_b_ff <= key_mem[rd_addr_b];
   end

   always_comb begin
      count_in = count_ff;
      emit_in  = emit_ff;
      if (req_take) begin
         emit_in = '0;
         if (store_room) begin
            count_in = CNT_W'(count_ff + 1'b1);
         end
      end
      if (state_ff == ST_EMIT_LD) begin
         emit_in = CNT_W'(emit_ff + 1'b1);
         if (emit_last) begin
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         emit_ff     <= '0;
         desc_cfg_ff <= 1'b0;
         desc_ff     <= 1'b0;
         hi_pend_ff  <= 1'b0;
         fwd_lo_ff   <= 1'b0;
         fwd_hi_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         emit_ff  <= emit_in;
         if (csr_wr_en) begin
            desc_cfg_ff <= csr_wr_data;
         end
         // The direction is taken when the last word of a set arrives.
         if (req_take && req_last_item) begin
            desc_ff <= desc_cfg_ff;
         end
         if (state_ff == ST_SORT_WR) begin
            hi_pend_ff <= 1'b1;
         end else if (state_ff == ST_SORT_RD) begin
            hi_pend_ff <= 1'b0;
         end
         if (issue) begin
            fwd_lo_ff <= hi_pend_ff && (hi_addr_ff == seq_lo);
            fwd_hi_ff <= hi_pend_ff && (hi_addr_ff == seq_hi);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         pair_lo_ff <= seq_lo;
         hi_addr_ff <= seq_hi;
      end
      if (state_ff == ST_SORT_WR) begin
         hi_key_ff <= cmp_max;
      end
   end

   // Result register: a word is loaded only when the previous one has left.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_EMIT_LD) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT_LD) begin
         rsp_key_ff  <= emit_key;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sorted_key = rsp_key_ff;
   assign rsp_last_out   = rsp_last_ff;

endmodule
